// ----- src/olt_pkg.sv -----
// Package for the offset/line table: command codes and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package olt_pkg;
    localparam int LINE_OUT_W = 24;
    localparam int CMD_W      = 2;

    localparam logic [CMD_W-1:0] CMD_RECORD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEAREST = 2'd2;

    typedef enum logic [1:0] {
        OP_RECORD,
        OP_LOOKUP,
        OP_NEAREST,
        OP_NONE
    } t_op;
endpackage
`default_nettype wire

// ----- src/olt_if.sv -----
// Valid/ready channel interfaces for items entering and results leaving the table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface olt_in_if #(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 24
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             cmd;
    logic [OFFSET_BITS-1:0] offset;
    logic [LINE_BITS-1:0]   line;
    modport source (output valid, cmd, offset, line, input ready);
    modport sink   (input valid, cmd, offset, line, output ready);
endinterface

interface olt_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] line_out;
    logic        status;
    modport source (output valid, line_out, status, input ready);
    modport sink   (input valid, line_out, status, output ready);
endinterface
`default_nettype wire

// ----- src/olt_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module olt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/olt_front.sv -----
// Front end: accepts items, decodes the command and queues them two deep.
// Depends on olt_pkg and olt_if.
`timescale 1ns / 1ps
`default_nettype none
module olt_front #(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    olt_in_if.sink                      i_in,
    output logic                        o_q_valid,
    input  wire logic                   i_q_pop,
    output olt_pkg::t_op                o_q_op,
    output logic [OFFSET_BITS-1:0]      o_q_key,
    output logic [LINE_BITS-1:0]        o_q_line
);
    import olt_pkg::*;

    t_op                    r_op   [2];
    logic [OFFSET_BITS-1:0] r_key  [2];
    logic [LINE_BITS-1:0]   r_line [2];
    logic                   r_wp, r_rp;
    logic [1:0]             r_cnt;
    t_op                    w_op;
    logic                   w_push, w_pop;

    // Classify the command
    always_comb begin
        unique case (i_in.cmd)
            CMD_RECORD:  w_op = OP_RECORD;
            CMD_LOOKUP:  w_op = OP_LOOKUP;
            CMD_NEAREST: w_op = OP_NEAREST;
            default:     w_op = OP_NONE;
        endcase
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_op     = r_op[r_rp];
    assign o_q_key    = r_key[r_rp];
    assign o_q_line   = r_line[r_rp];

    // Store items in the queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_op[r_wp]   <= w_op;
            r_key[r_wp]  <= i_in.offset;
            r_line[r_wp] <= i_in.line;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ----- src/olt_back.sv -----
// Back end: scans, inserts and shifts table entries in RAM and registers results.
// Depends on olt_pkg, olt_if and olt_ram.
`timescale 1ns / 1ps
`default_nettype none
module olt_back #(
    parameter int ENTRIES     = 256,
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    output logic                        o_q_pop,
    input  var  olt_pkg::t_op           i_q_op,
    input  wire logic [OFFSET_BITS-1:0] i_q_key,
    input  wire logic [LINE_BITS-1:0]   i_q_line,
    olt_out_if.source                   o_out
);
    import olt_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int DW = OFFSET_BITS + LINE_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CHK, S_INS, S_SHRD, S_SHWR, S_FIN
    } t_state;

    t_state                 r_state;
    t_op                    r_op;
    logic [OFFSET_BITS-1:0] r_key;
    logic [LINE_BITS-1:0]   r_q;
    logic [CW-1:0]          r_i, r_pos, r_count;
    logic [LINE_BITS-1:0]   r_best, r_res_line;
    logic                   r_found, r_res_st;
    logic                   r_ov;
    logic [LINE_OUT_W-1:0]  r_line_out;
    logic                   r_status;

    logic                   w_we;
    logic [AW-1:0]          w_waddr, w_raddr;
    logic [DW-1:0]          w_wdata, w_rdata;
    logic [OFFSET_BITS-1:0] w_off;
    logic [LINE_BITS-1:0]   w_ln, w_lk_best, w_nr_best;
    logic                   w_last, w_nr_take, w_nr_found;
    logic [CW-1:0]          w_im1;
    logic [LINE_BITS+LINE_OUT_W-1:0] w_ext;

    olt_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_off  = w_rdata[DW-1:LINE_BITS];
    assign w_ln   = w_rdata[LINE_BITS-1:0];
    assign w_im1  = r_i - 1'b1;
    assign w_last = (r_i + 1'b1 == r_count);

    // Running best for lookups and nearest-line queries
    assign w_lk_best  = ((r_i == '0) || (w_off <= r_key)) ? w_ln : r_best;
    assign w_nr_take  = (w_ln >= r_q) && (!r_found || (w_ln < r_best));
    assign w_nr_found = r_found || w_nr_take;
    assign w_nr_best  = w_nr_take ? w_ln : r_best;

    // Select RAM addresses and write data
    always_comb begin
        w_raddr = (r_state == S_SHRD) ? w_im1[AW-1:0] : r_i[AW-1:0];
        w_we    = 1'b0;
        w_waddr = r_i[AW-1:0];
        w_wdata = w_rdata;
        unique case (r_state)
            S_CHK: begin
                if (r_op == OP_RECORD && w_off == r_key) begin
                    w_we    = 1'b1;
                    w_wdata = {r_key, r_q};
                end
            end
            S_SHWR: w_we = 1'b1;
            S_INS: begin
                if (r_count != CW'(ENTRIES) && !(r_i > r_pos)) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos[AW-1:0];
                    w_wdata = {r_key, r_q};
                end
            end
            default: ;
        endcase
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign w_ext   = {{LINE_OUT_W{1'b0}}, r_res_line};

    // Sequence one item at a time and hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && o_out.ready && r_state != S_FIN) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_op       <= i_q_op;
                        r_key      <= i_q_key;
                        r_q        <= i_q_line;
                        r_i        <= '0;
                        r_found    <= 1'b0;
                        r_res_line <= (i_q_op == OP_LOOKUP && r_count == '0) ?
                                      LINE_BITS'(1) : '0;
                        r_res_st   <= 1'b0;
                        if (i_q_op == OP_NONE) begin
                            r_state <= S_FIN;
                        end else if (r_count != '0) begin
                            r_state <= S_RD;
                        end else if (i_q_op == OP_RECORD) begin
                            r_pos   <= '0;
                            r_state <= S_INS;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    unique case (r_op)
                        OP_RECORD: begin
                            if (w_off == r_key) begin
                                r_state <= S_FIN;
                            end else if (w_off > r_key) begin
                                r_pos   <= r_i;
                                r_i     <= r_count;
                                r_state <= S_INS;
                            end else if (w_last) begin
                                r_pos   <= r_count;
                                r_i     <= r_count;
                                r_state <= S_INS;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_RD;
                            end
                        end
                        OP_LOOKUP: begin
                            if (w_off > r_key || w_last) begin
                                r_res_line <= w_lk_best;
                                r_state    <= S_FIN;
                            end else begin
                                r_best  <= w_lk_best;
                                r_i     <= r_i + 1'b1;
                                r_state <= S_RD;
                            end
                        end
                        default: begin
                            r_best  <= w_nr_best;
                            r_found <= w_nr_found;
                            if (w_last) begin
                                r_res_line <= w_nr_found ? w_nr_best : '0;
                                r_state    <= S_FIN;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_RD;
                            end
                        end
                    endcase
                end
                S_INS: begin
                    if (r_count == CW'(ENTRIES)) begin
                        r_res_st <= 1'b1;
                        r_state  <= S_FIN;
                    end else if (r_i > r_pos) begin
                        r_state <= S_SHRD;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_SHRD: r_state <= S_SHWR;
                S_SHWR: begin
                    r_i     <= w_im1;
                    r_state <= S_INS;
                end
                S_FIN: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov       <= 1'b1;
                        r_line_out <= w_ext[LINE_OUT_W-1:0];
                        r_status   <= r_res_st;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.line_out = r_line_out;
    assign o_out.status   = r_status;
endmodule
`default_nettype wire

// ----- src/offset_line_table.sv -----
// Ordered offset/line table. A lookup or nearest-line query reads and checks the
// stored entries in turn; a record that inserts first shifts each later entry up
// one place, and a full table drops it. The entry RAM's single read port
// sets the rate; a two-item queue lets input and result sides stall on their own.
// Reset empties the table (count cleared) and the queue; no clearing pass.
// Depends on olt_pkg, olt_if, olt_front and olt_back.
`timescale 1ns / 1ps
`default_nettype none
module offset_line_table #(
    parameter int ENTRIES     = 256,
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    olt_in_if.sink    i_in,
    olt_out_if.source o_out
);
    import olt_pkg::*;

    logic                   w_q_valid, w_q_pop;
    t_op                    w_q_op;
    logic [OFFSET_BITS-1:0] w_q_key;
    logic [LINE_BITS-1:0]   w_q_line;

    olt_front #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_op    (w_q_op),
        .o_q_key   (w_q_key),
        .o_q_line  (w_q_line)
    );

    olt_back #(
        .ENTRIES(ENTRIES), .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_op    (w_q_op),
        .i_q_key   (w_q_key),
        .i_q_line  (w_q_line),
        .o_out     (o_out)
    );
endmodule
`default_nettype wire
